// ===== design/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_PAYLOAD,
    PH_CLOSED
  } wsd_phase_t;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic [1:0] KEY_LAST = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last_of_message;
  } wsd_res_t;

  typedef struct packed {
    logic     valid;
    wsd_res_t res;
  } wsd_push_t;

endpackage

// ===== design/websocket_frame_deframer_top.sv =====
// Top level of the WebSocket frame deframer: parser, result queue and output stage.
//
// Receives a WebSocket frame stream one byte per beat and returns unmasked text
// payload bytes (last byte flagged), an empty-message marker for empty text
// frames, and a close marker after a close frame, after which all bytes are
// dropped until reset. The parser takes one byte every cycle while in_ready is
// high; each byte is resolved in the cycle it is accepted, the critical path
// being the 64-bit payload length down-counter and its compare. Results go
// into a queue of QUEUE_DEPTH entries and from there into the output register,
// from which they are offered. in_ready falls only while the queue is full,
// which for QUEUE_DEPTH above 1 happens only after out_ready has been held low
// long enough to back up QUEUE_DEPTH results. QUEUE_DEPTH must be at least 1.
module websocket_frame_deframer_top
  import wsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_payload_byte,
  output logic       out_last_of_message
);

  wsd_push_t push;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  wsd_res_t  q_data;
  wsd_res_t  out_res;
  logic      in_fire;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  wsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .rx_byte (in_rx_byte),
    .push    (push)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  wsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind            = out_res.kind;
  assign out_payload_byte    = out_res.payload_byte;
  assign out_last_of_message = out_res.last_of_message;

endmodule

// ===== design/wsd_front.sv =====
// Front end: per-byte frame parser that classifies bytes and emits results.
module wsd_front
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output wsd_push_t  push
);

  wsd_phase_t  phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [63:0] rem_len_r, rem_len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;

  logic        ld_go;
  logic        ld_mask;
  logic        hd_go;
  logic [63:0] hd_rem;
  logic [7:0]  key_byte;
  logic [7:0]  plain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      opcode_r   <= '0;
      mask_r     <= 1'b0;
      ext_left_r <= '0;
      rem_len_r  <= '0;
      key_r      <= '0;
      key_idx_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      mask_r     <= mask_nxt;
      ext_left_r <= ext_left_nxt;
      rem_len_r  <= rem_len_nxt;
      key_r      <= key_nxt;
      key_idx_r  <= key_idx_nxt;
    end
  end

  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
    plain = rx_byte ^ key_byte;
  end

  always_comb begin
    phase_nxt    = phase_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    ext_left_nxt = ext_left_r;
    rem_len_nxt  = rem_len_r;
    key_nxt      = key_r;
    key_idx_nxt  = key_idx_r;
    ld_go        = 1'b0;
    ld_mask      = mask_r;
    hd_go        = 1'b0;
    hd_rem       = rem_len_r;
    push         = '0;

    if (fire) begin
      case (phase_r)
        PH_HDR0: begin
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_nxt    = rx_byte[7];
          key_nxt     = '0;
          rem_len_nxt = '0;
          if (rx_byte[6:0] == LEN_EXT16) begin
            ext_left_nxt = EXT16_BYTES;
            phase_nxt    = PH_EXT;
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            ext_left_nxt = EXT64_BYTES;
            phase_nxt    = PH_EXT;
          end else begin
            ext_left_nxt = '0;
            rem_len_nxt  = {57'd0, rx_byte[6:0]};
            ld_go        = 1'b1;
            ld_mask      = rx_byte[7];
            hd_rem       = {57'd0, rx_byte[6:0]};
          end
        end
        PH_EXT: begin
          rem_len_nxt  = {rem_len_r[55:0], rx_byte};
          ext_left_nxt = ext_left_r - 4'd1;
          hd_rem       = {rem_len_r[55:0], rx_byte};
          ld_go        = (ext_left_nxt == 4'd0);
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          if (key_idx_r != KEY_LAST) begin
            key_idx_nxt = key_idx_r + 2'd1;
          end else begin
            hd_go = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          key_idx_nxt = key_idx_r + 2'd1;
          rem_len_nxt = rem_len_r - 64'd1;
          if (rem_len_r == 64'd1) begin
            if (opcode_r == OP_CLOSE) begin
              phase_nxt       = PH_CLOSED;
              push.valid      = 1'b1;
              push.res.kind   = KIND_CLOSE;
            end else begin
              phase_nxt = PH_HDR0;
              if (opcode_r == OP_TEXT) begin
                push.valid               = 1'b1;
                push.res.kind            = KIND_TEXT;
                push.res.payload_byte    = plain;
                push.res.last_of_message = 1'b1;
              end
            end
          end else if (opcode_r == OP_TEXT) begin
            push.valid            = 1'b1;
            push.res.kind         = KIND_TEXT;
            push.res.payload_byte = plain;
          end
        end
        PH_CLOSED: begin
          phase_nxt = PH_CLOSED;
        end
        default: begin
          phase_nxt = PH_CLOSED;
        end
      endcase

      if (ld_go) begin
        if (ld_mask) begin
          key_idx_nxt = '0;
          phase_nxt   = PH_KEY;
        end else begin
          hd_go = 1'b1;
        end
      end

      if (hd_go) begin
        key_idx_nxt = '0;
        if (hd_rem != 64'd0) begin
          phase_nxt = PH_PAYLOAD;
        end else if (opcode_r == OP_CLOSE) begin
          phase_nxt     = PH_CLOSED;
          push.valid    = 1'b1;
          push.res.kind = KIND_CLOSE;
        end else begin
          phase_nxt = PH_HDR0;
          if (opcode_r == OP_TEXT) begin
            push.valid    = 1'b1;
            push.res.kind = KIND_EMPTY;
          end
        end
      end
    end
  end

endmodule

// ===== design/wsd_queue.sv =====
// Result queue between the parser and the output stage.
module wsd_queue
  import wsd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  wsd_push_t push,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output wsd_res_t  q_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsd_res_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.res;
    end
  end

endmodule

// ===== design/wsd_back.sv =====
// Back end: output register that drains the queue onto the result channel.
module wsd_back
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  wsd_res_t q_data,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output wsd_res_t out_res
);

  logic     valid_r, valid_nxt;
  wsd_res_t res_r;

  assign pop       = q_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= q_data;
    end
  end

endmodule
